@@ design/cmrps_pkg.sv @@
package cmrps_pkg;

	localparam int LOG2_SAMPLES    = 2;
	localparam int SEGMENT_SAMPLES = 1 << LOG2_SAMPLES;
	localparam int SAMPLE_W        = (LOG2_SAMPLES > 0) ? LOG2_SAMPLES : 1;

	localparam int NUM_AXES = 3;
	localparam int COORD_W  = 32;
	localparam int PT_W     = COORD_W + 2;
	localparam int COEF_W   = PT_W + 4;
	localparam int WEIGHT_W = 3 * LOG2_SAMPLES + 1;
	localparam int SHIFT    = 3 * LOG2_SAMPLES + 1;
	localparam int PROD_W   = COEF_W + WEIGHT_W + 1;
	localparam int SUM_W    = PROD_W + 2;
	localparam int VAL_W    = SUM_W - SHIFT;

	localparam int JQ_DEPTH = 2;
	localparam int JQ_PTR_W = (JQ_DEPTH > 2) ? $clog2(JQ_DEPTH) : 1;
	localparam int JQ_CNT_W = $clog2(JQ_DEPTH + 1);

	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = (OQ_DEPTH > 2) ? $clog2(OQ_DEPTH) : 1;
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [PT_W-1:0]    pt_t;
	typedef logic signed [COEF_W-1:0]  coef_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [SUM_W-1:0]   sum_t;
	typedef logic signed [VAL_W-1:0]   val_t;

	typedef coord_t [NUM_AXES-1:0] coord_vec_t;
	typedef pt_t    [NUM_AXES-1:0] pt_vec_t;
	typedef coef_t  [NUM_AXES-1:0] coef_vec_t;
	typedef prod_t  [NUM_AXES-1:0] prod_vec_t;
	typedef val_t   [NUM_AXES-1:0] val_vec_t;

	typedef struct packed {
		pt_vec_t    p0;
		coord_vec_t p1;
		pt_vec_t    p2;
		pt_vec_t    p3;
		logic       single;
		logic       run_last;
		logic       path_done;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} jq_status_t;

	typedef struct packed {
		coord_vec_t smp;
		logic       clipped;
		logic       run_last;
		logic       path_done;
	} result_t;

	function automatic logic [WEIGHT_W-1:0] weight_lin(input logic [SAMPLE_W-1:0] s);
		logic [WEIGHT_W-1:0] se;
		se = WEIGHT_W'(s);
		return se << (2 * LOG2_SAMPLES);
	endfunction

	function automatic logic [WEIGHT_W-1:0] weight_sq(input logic [SAMPLE_W-1:0] s);
		logic [WEIGHT_W-1:0] se;
		logic [WEIGHT_W-1:0] sq;
		se = WEIGHT_W'(s);
		sq = se * se;
		return sq << LOG2_SAMPLES;
	endfunction

	function automatic logic [WEIGHT_W-1:0] weight_cub(input logic [SAMPLE_W-1:0] s);
		logic [WEIGHT_W-1:0] se;
		logic [WEIGHT_W-1:0] sq;
		se = WEIGHT_W'(s);
		sq = se * se;
		return sq * se;
	endfunction

endpackage

@@ design/catmull_rom_path_sampler.sv @@
// Waypoints go in through a queue-style port and smoothed Catmull-Rom samples come out of
// another; each segment is released when the waypoint after it arrives, or at the final
// waypoint, which also closes the path with the waypoint itself. The sampling unit makes one
// sample per cycle while the output queue has room, so a segment gives SEGMENT_SAMPLES samples
// (four) and a final waypoint point one more; a final waypoint yields up to 2*SEGMENT_SAMPLES+1
// samples. The front end queues the jobs of a waypoint one at a time, the closing waypoint
// job included, and a two-entry job queue lets it run ahead of the sampler. A sample passes a
// coefficient register, two arithmetic stages and an output queue on its way from the job
// queue to the result ports.
module catmull_rom_path_sampler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [31:0] coord_x,
	input  logic [31:0] coord_y,
	input  logic [31:0] coord_z,
	input  logic        final_waypoint,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] sample_x,
	output logic [31:0] sample_y,
	output logic [31:0] sample_z,
	output logic        clipped,
	output logic        run_last,
	output logic        path_done
);

	cmrps_pkg::coord_vec_t coords;
	cmrps_pkg::jq_status_t jq_stat;
	cmrps_pkg::job_t       job_in;
	cmrps_pkg::job_t       job_out;
	cmrps_pkg::result_t    result;
	logic                  jq_push;
	logic                  jq_pop;

	assign coords = {coord_z, coord_y, coord_x};

	cmrps_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.coords         (coords),
		.final_waypoint (final_waypoint),
		.jq_stat        (jq_stat),
		.jq_push        (jq_push),
		.job            (job_in)
	);

	cmrps_job_queue u_job_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (jq_push),
		.din    (job_in),
		.pop    (jq_pop),
		.stat   (jq_stat),
		.dout   (job_out)
	);

	cmrps_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.jq_stat (jq_stat),
		.jq_pop  (jq_pop),
		.job     (job_out),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

	assign sample_x  = result.smp[0];
	assign sample_y  = result.smp[1];
	assign sample_z  = result.smp[2];
	assign clipped   = result.clipped;
	assign run_last  = result.run_last;
	assign path_done = result.path_done;

	a_job_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		jq_push |-> !jq_stat.full)
		else $error("Job written into a full job queue.");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && path_done) |-> (run_last && !clipped))
		else $error("Path end item is not the last of its run or is clipped.");

	a_pop_needs_job: assert property (@(posedge clk) disable iff (!arst_n)
		jq_pop |-> !jq_stat.empty)
		else $error("Sampler took a job from an empty job queue.");

endmodule

@@ design/cmrps_front.sv @@
module cmrps_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  cmrps_pkg::coord_vec_t  coords,
	input  logic                   final_waypoint,
	input  cmrps_pkg::jq_status_t  jq_stat,
	output logic                   jq_push,
	output cmrps_pkg::job_t        job
);

	localparam int JB_SEG1 = 0;
	localparam int JB_SEG2 = 1;
	localparam int JB_FIN  = 2;

	logic                  pend_valid_q;
	cmrps_pkg::coord_vec_t pend_pt_q;
	logic                  pend_last_q;
	logic [2:0]            iss_q;
	cmrps_pkg::coord_vec_t win0_q;
	cmrps_pkg::coord_vec_t win1_q;
	cmrps_pkg::coord_vec_t win2_q;
	logic [1:0]            held_q;

	logic [2:0] need;
	logic [2:0] cur;
	logic [2:0] rest;
	logic       done_now;
	logic       accept;

	always_comb begin
		need[JB_SEG1] = (held_q >= 2'd2);
		need[JB_SEG2] = pend_last_q && (held_q != 2'd0);
		need[JB_FIN]  = pend_last_q;
		need          = need & ~iss_q;
		cur           = need & (~need + 3'd1);
		jq_push       = pend_valid_q && (|need) && !jq_stat.full;
		rest          = need & ~(jq_push ? cur : 3'd0);
		done_now      = pend_valid_q && (rest == 3'd0);
		full          = pend_valid_q && !done_now;
		accept        = push && !full;
	end

	always_comb begin
		cmrps_pkg::pt_t pp;
		cmrps_pkg::pt_t px;
		cmrps_pkg::pt_t pa;
		cmrps_pkg::pt_t pb;
		job = '0;
		for (int a = 0; a < cmrps_pkg::NUM_AXES; a++) begin
			pp = cmrps_pkg::pt_t'($signed(pend_pt_q[a]));
			px = cmrps_pkg::pt_t'($signed(win0_q[a]));
			pa = cmrps_pkg::pt_t'($signed(win1_q[a]));
			pb = cmrps_pkg::pt_t'($signed(win2_q[a]));
			if (cur[JB_SEG1]) begin
				job.p0[a] = (held_q == 2'd2) ? ((pa <<< 1) - pb) : px;
				job.p1[a] = win1_q[a];
				job.p2[a] = pb;
				job.p3[a] = pp;
			end else if (cur[JB_SEG2]) begin
				job.p0[a] = (held_q == 2'd1) ? ((pb <<< 1) - pp) : pa;
				job.p1[a] = win2_q[a];
				job.p2[a] = pp;
				job.p3[a] = (pp <<< 1) - pb;
			end else begin
				job.p0[a] = pp;
				job.p1[a] = pend_pt_q[a];
				job.p2[a] = pp;
				job.p3[a] = pp;
			end
		end
		job.single    = cur[JB_FIN];
		job.path_done = cur[JB_FIN];
		job.run_last  = (rest == 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			pend_last_q  <= 1'b0;
			iss_q        <= '0;
		end else if (accept) begin
			pend_valid_q <= 1'b1;
			pend_last_q  <= final_waypoint;
			iss_q        <= '0;
		end else if (done_now) begin
			pend_valid_q <= 1'b0;
		end else if (jq_push) begin
			iss_q <= iss_q | cur;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_pt_q <= coords;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win0_q <= '0;
			win1_q <= '0;
			win2_q <= '0;
			held_q <= '0;
		end else if (done_now) begin
			if (pend_last_q) begin
				win0_q <= '0;
				win1_q <= '0;
				win2_q <= '0;
				held_q <= '0;
			end else begin
				win0_q <= win1_q;
				win1_q <= win2_q;
				win2_q <= pend_pt_q;
				held_q <= (held_q == 2'd3) ? 2'd3 : held_q + 2'd1;
			end
		end
	end

endmodule

@@ design/cmrps_job_queue.sv @@
module cmrps_job_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  cmrps_pkg::job_t       din,
	input  logic                  pop,
	output cmrps_pkg::jq_status_t stat,
	output cmrps_pkg::job_t       dout
);

	cmrps_pkg::job_t                  ents_q [cmrps_pkg::JQ_DEPTH];
	logic [cmrps_pkg::JQ_PTR_W-1:0]   wr_ptr_q;
	logic [cmrps_pkg::JQ_PTR_W-1:0]   rd_ptr_q;
	logic [cmrps_pkg::JQ_CNT_W-1:0]   count_q;
	logic                             do_push;
	logic                             do_pop;

	assign stat.full  = (count_q == cmrps_pkg::JQ_CNT_W'(cmrps_pkg::JQ_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign dout       = ents_q[rd_ptr_q];

	function automatic logic [cmrps_pkg::JQ_PTR_W-1:0] ptr_next(
		input logic [cmrps_pkg::JQ_PTR_W-1:0] p);
		return (p == cmrps_pkg::JQ_PTR_W'(cmrps_pkg::JQ_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ents_q[wr_ptr_q] <= din;
		end
	end

endmodule

@@ design/cmrps_back.sv @@
module cmrps_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmrps_pkg::jq_status_t jq_stat,
	output logic                  jq_pop,
	input  cmrps_pkg::job_t       job,
	input  logic                  pop,
	output logic                  empty,
	output cmrps_pkg::result_t    result
);

	logic                             cur_valid_q;
	logic [cmrps_pkg::SAMPLE_W-1:0]   s_q;
	cmrps_pkg::coord_vec_t            p1_q;
	cmrps_pkg::coef_vec_t             d1_q;
	cmrps_pkg::coef_vec_t             d2_q;
	cmrps_pkg::coef_vec_t             d3_q;
	logic                             single_q;
	logic                             run_last_q;
	logic                             done_q;

	logic                             valid_s1;
	cmrps_pkg::prod_vec_t             prod1_s1;
	cmrps_pkg::prod_vec_t             prod2_s1;
	cmrps_pkg::prod_vec_t             prod3_s1;
	cmrps_pkg::coord_vec_t            p1_s1;
	logic                             run_last_s1;
	logic                             done_s1;

	logic                             valid_s2;
	cmrps_pkg::val_vec_t              val_s2;
	logic                             run_last_s2;
	logic                             done_s2;

	cmrps_pkg::result_t               oq_q [cmrps_pkg::OQ_DEPTH];
	logic [cmrps_pkg::OQ_PTR_W-1:0]   oq_wr_q;
	logic [cmrps_pkg::OQ_PTR_W-1:0]   oq_rd_q;
	logic [cmrps_pkg::OQ_CNT_W-1:0]   oq_cnt_q;

	logic                             last_smp;
	logic [cmrps_pkg::OQ_CNT_W:0]     inflight;
	logic                             issue;
	logic                             oq_pop;
	cmrps_pkg::coef_vec_t             d1_new;
	cmrps_pkg::coef_vec_t             d2_new;
	cmrps_pkg::coef_vec_t             d3_new;
	cmrps_pkg::val_vec_t              val_new;
	cmrps_pkg::result_t               res_new;

	function automatic logic [cmrps_pkg::OQ_PTR_W-1:0] ptr_next(
		input logic [cmrps_pkg::OQ_PTR_W-1:0] p);
		return (p == cmrps_pkg::OQ_PTR_W'(cmrps_pkg::OQ_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_comb begin
		last_smp = single_q
			|| (s_q == cmrps_pkg::SAMPLE_W'(cmrps_pkg::SEGMENT_SAMPLES - 1));
		inflight = {1'b0, oq_cnt_q} + (cmrps_pkg::OQ_CNT_W + 1)'(valid_s1)
			+ (cmrps_pkg::OQ_CNT_W + 1)'(valid_s2);
		issue    = cur_valid_q
			&& (inflight < (cmrps_pkg::OQ_CNT_W + 1)'(cmrps_pkg::OQ_DEPTH));
		jq_pop   = !jq_stat.empty && (!cur_valid_q || (issue && last_smp));
	end

	always_comb begin
		cmrps_pkg::coef_t e0;
		cmrps_pkg::coef_t e1;
		cmrps_pkg::coef_t e2;
		cmrps_pkg::coef_t e3;
		for (int a = 0; a < cmrps_pkg::NUM_AXES; a++) begin
			e0 = cmrps_pkg::coef_t'($signed(job.p0[a]));
			e1 = cmrps_pkg::coef_t'($signed(job.p1[a]));
			e2 = cmrps_pkg::coef_t'($signed(job.p2[a]));
			e3 = cmrps_pkg::coef_t'($signed(job.p3[a]));
			d1_new[a] = e2 - e0;
			d2_new[a] = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
			d3_new[a] = (e1 <<< 1) + e1 - (e2 <<< 1) - e2 + e3 - e0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			s_q         <= '0;
		end else if (jq_pop) begin
			cur_valid_q <= 1'b1;
			s_q         <= '0;
		end else if (issue && last_smp) begin
			cur_valid_q <= 1'b0;
		end else if (issue) begin
			s_q <= s_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (jq_pop) begin
			p1_q       <= job.p1;
			d1_q       <= d1_new;
			d2_q       <= d2_new;
			d3_q       <= d3_new;
			single_q   <= job.single;
			run_last_q <= job.run_last;
			done_q     <= job.path_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			for (int a = 0; a < cmrps_pkg::NUM_AXES; a++) begin
				prod1_s1[a] <= $signed(d1_q[a]) * $signed({1'b0, cmrps_pkg::weight_lin(s_q)});
				prod2_s1[a] <= $signed(d2_q[a]) * $signed({1'b0, cmrps_pkg::weight_sq(s_q)});
				prod3_s1[a] <= $signed(d3_q[a]) * $signed({1'b0, cmrps_pkg::weight_cub(s_q)});
			end
			p1_s1       <= p1_q;
			run_last_s1 <= run_last_q && last_smp;
			done_s1     <= done_q;
		end
	end

	always_comb begin
		cmrps_pkg::sum_t total;
		for (int a = 0; a < cmrps_pkg::NUM_AXES; a++) begin
			total = cmrps_pkg::sum_t'($signed(prod1_s1[a]))
				+ cmrps_pkg::sum_t'($signed(prod2_s1[a]))
				+ cmrps_pkg::sum_t'($signed(prod3_s1[a]))
				+ (cmrps_pkg::sum_t'($signed(p1_s1[a])) <<< cmrps_pkg::SHIFT)
				+ (cmrps_pkg::sum_t'(1) <<< (cmrps_pkg::SHIFT - 1));
			val_new[a] = cmrps_pkg::val_t'(total >>> cmrps_pkg::SHIFT);
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			val_s2      <= val_new;
			run_last_s2 <= run_last_s1;
			done_s2     <= done_s1;
		end
	end

	always_comb begin
		logic [cmrps_pkg::VAL_W-cmrps_pkg::COORD_W:0] hi;
		logic                                         fits;
		res_new = '0;
		for (int a = 0; a < cmrps_pkg::NUM_AXES; a++) begin
			hi   = val_s2[a][cmrps_pkg::VAL_W-1:cmrps_pkg::COORD_W-1];
			fits = (&hi) || !(|hi);
			if (fits) begin
				res_new.smp[a] = val_s2[a][cmrps_pkg::COORD_W-1:0];
			end else if (val_s2[a][cmrps_pkg::VAL_W-1]) begin
				res_new.smp[a] = {1'b1, {(cmrps_pkg::COORD_W - 1){1'b0}}};
			end else begin
				res_new.smp[a] = {1'b0, {(cmrps_pkg::COORD_W - 1){1'b1}}};
			end
			res_new.clipped = res_new.clipped || !fits;
		end
		res_new.run_last  = run_last_s2;
		res_new.path_done = done_s2;
	end

	assign empty  = (oq_cnt_q == '0);
	assign oq_pop = pop && !empty;
	assign result = oq_q[oq_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (valid_s2) begin
				oq_wr_q <= ptr_next(oq_wr_q);
			end
			if (oq_pop) begin
				oq_rd_q <= ptr_next(oq_rd_q);
			end
			if (valid_s2 && !oq_pop) begin
				oq_cnt_q <= oq_cnt_q + 1'b1;
			end else if (oq_pop && !valid_s2) begin
				oq_cnt_q <= oq_cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			oq_q[oq_wr_q] <= res_new;
		end
	end

endmodule
